[rtl/core/bnc_pkg.sv]
// shared types and constants of the bracket nesting checker
package bnc_pkg;

    // bracket stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bracket characters
    localparam logic [7:0] CH_LROUND  = 8'h28;
    localparam logic [7:0] CH_RROUND  = 8'h29;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;

    // bracket kinds as held on the stack
    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_CURLY  = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // verdict status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_OPEN     = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // stack operation decoded from one byte
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    // one decoded item travelling through the queue
    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        logic       last;
    } item_t;

endpackage

[rtl/core/bnc_front.sv]
// front part: takes byte beats and decodes them into stack operations
module bnc_front (
    input  logic              char_valid,
    output logic              char_ready,
    input  logic [7:0]        char_in,
    input  logic              is_last,
    input  logic              q_full,
    output logic              q_push,
    output bnc_pkg::item_t    q_item
);

    // byte decode
    always_comb
    begin
        q_item.last = is_last;
        case (char_in)
            bnc_pkg::CH_LROUND:
            begin
                q_item.op   = bnc_pkg::OP_PUSH;
                q_item.kind = bnc_pkg::KIND_ROUND;
            end
            bnc_pkg::CH_LCURLY:
            begin
                q_item.op   = bnc_pkg::OP_PUSH;
                q_item.kind = bnc_pkg::KIND_CURLY;
            end
            bnc_pkg::CH_LSQUARE:
            begin
                q_item.op   = bnc_pkg::OP_PUSH;
                q_item.kind = bnc_pkg::KIND_SQUARE;
            end
            bnc_pkg::CH_RROUND:
            begin
                q_item.op   = bnc_pkg::OP_POP;
                q_item.kind = bnc_pkg::KIND_ROUND;
            end
            bnc_pkg::CH_RCURLY:
            begin
                q_item.op   = bnc_pkg::OP_POP;
                q_item.kind = bnc_pkg::KIND_CURLY;
            end
            bnc_pkg::CH_RSQUARE:
            begin
                q_item.op   = bnc_pkg::OP_POP;
                q_item.kind = bnc_pkg::KIND_SQUARE;
            end
            default:
            begin
                q_item.op   = bnc_pkg::OP_NONE;
                q_item.kind = bnc_pkg::KIND_NONE;
            end
        endcase
    end

    // accept whenever the queue has room
    assign char_ready = !q_full;
    assign q_push     = char_valid && !q_full;

endmodule

[rtl/core/bnc_queue.sv]
// short queue of decoded items between front and back
module bnc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bnc_pkg::item_t       push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output bnc_pkg::item_t       head_item
);

    bnc_pkg::item_t                   slot_reg [bnc_pkg::QUEUE_DEPTH];
    logic [bnc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bnc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bnc_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    assign full       = (cnt_reg == bnc_pkg::QCNT_W'(bnc_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/bnc_back.sv]
// back part: bracket stack, sticky failure code and result register
module bnc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  bnc_pkg::item_t    head_item,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              balanced,
    output logic [1:0]        status
);

    // stack storage below the top entry
    logic [1:0]                    mem [bnc_pkg::STACK_DEPTH];
    logic [1:0]                    rd_data_reg;
    logic                          byp_reg;
    logic [1:0]                    byp_data_reg;

    // top entry, count and failure
    logic [1:0]                    tos_reg, tos_next;
    logic [bnc_pkg::CNT_W-1:0]     count_reg, count_next;
    bnc_pkg::status_t              fail_reg, fail_next;

    // result register
    logic                          res_valid_reg, res_valid_next;
    logic                          bal_reg;
    bnc_pkg::status_t              stat_reg;

    logic                          slot_free;
    logic                          wr_en;
    logic [bnc_pkg::ADDR_W-1:0]    wr_addr;
    logic [bnc_pkg::CNT_W-1:0]     wr_addr_full;
    logic [bnc_pkg::ADDR_W-1:0]    rd_addr;
    logic [bnc_pkg::CNT_W-1:0]     rd_addr_full;
    logic [1:0]                    below;
    logic [bnc_pkg::CNT_W-1:0]     cnt_upd;
    bnc_pkg::status_t              fail_upd;
    bnc_pkg::status_t              verdict;

    // a final beat needs the result slot, other beats go straight through
    assign slot_free = !res_valid_reg || result_ready;
    assign pop       = head_valid && (!head_item.last || slot_free);

    // entry just under the top, forwarded if it was written last cycle
    assign below = byp_reg ? byp_data_reg : rd_data_reg;

    assign wr_addr_full = count_reg - bnc_pkg::CNT_W'(1);
    assign wr_addr      = wr_addr_full[bnc_pkg::ADDR_W-1:0];

    // stack step for the head item
    always_comb
    begin
        fail_upd = fail_reg;
        cnt_upd  = count_reg;
        tos_next = tos_reg;
        wr_en    = 1'b0;
        if (pop && (fail_reg == bnc_pkg::ST_OK))
        begin
            case (head_item.op)
                bnc_pkg::OP_PUSH:
                begin
                    if (count_reg == bnc_pkg::CNT_W'(bnc_pkg::STACK_DEPTH))
                    begin
                        fail_upd = bnc_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en    = (count_reg != '0);
                        tos_next = head_item.kind;
                        cnt_upd  = count_reg + 1'b1;
                    end
                end
                bnc_pkg::OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        fail_upd = bnc_pkg::ST_MISMATCH;
                    end
                    else
                    begin
                        cnt_upd  = count_reg - 1'b1;
                        tos_next = below;
                        if (tos_reg != head_item.kind)
                        begin
                            fail_upd = bnc_pkg::ST_MISMATCH;
                        end
                    end
                end
                default:
                begin
                    fail_upd = fail_reg;
                end
            endcase
        end
    end

    // verdict after this beat
    always_comb
    begin
        if (fail_upd != bnc_pkg::ST_OK)
        begin
            verdict = fail_upd;
        end
        else if (cnt_upd != '0)
        begin
            verdict = bnc_pkg::ST_OPEN;
        end
        else
        begin
            verdict = bnc_pkg::ST_OK;
        end
    end

    // final beat clears the expression state
    always_comb
    begin
        if (pop && head_item.last)
        begin
            count_next = '0;
            fail_next  = bnc_pkg::ST_OK;
        end
        else
        begin
            count_next = cnt_upd;
            fail_next  = fail_upd;
        end
    end

    assign rd_addr_full = count_next - bnc_pkg::CNT_W'(2);
    assign rd_addr      = rd_addr_full[bnc_pkg::ADDR_W-1:0];

    // result slot
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && head_item.last)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fail_reg      <= bnc_pkg::ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fail_reg      <= fail_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (pop && head_item.last)
        begin
            bal_reg  <= (verdict == bnc_pkg::ST_OK);
            stat_reg <= verdict;
        end
    end

    // stack memory with registered read and write forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= tos_reg;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_reg      <= wr_en && (wr_addr == rd_addr);
        byp_data_reg <= tos_reg;
    end

    assign result_valid = res_valid_reg;
    assign balanced     = bal_reg;
    assign status       = stat_reg;

endmodule

[rtl/core/bracket_nesting_checker_unit.sv]
// Bracket nesting checker: takes one text byte per beat and, on the beat
// flagged is_last, gives one result with the verdict (balanced) and a status
// (ok, mismatch or stray close, left open, overflow). It sustains one byte per
// clock: the front decodes each byte into a push, a pop or nothing, a
// four-entry queue carries it to the back, and the back does one stack step
// per cycle on a 128 x 2-bit memory with a registered read, keeping the top
// entry in a register and forwarding a just-written entry. The final byte is
// registered in the queue and then, when the result slot is free, in the
// result register that drives the result beat; while an earlier result is
// still held, the final byte waits at the head of the queue, and once the
// queue is full the input stalls. The stack needs no clearing after reset or
// between expressions: only entries below the count are ever used.
module bracket_nesting_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_in,
    input  logic        is_last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        balanced,
    output logic [1:0]  status
);

    logic             q_full;
    logic             q_push;
    bnc_pkg::item_t   q_item;
    logic             q_pop;
    logic             head_valid;
    bnc_pkg::item_t   head_item;

    // byte decode
    bnc_front u_front (
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_in    (char_in),
        .is_last    (is_last),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    // decoupling queue
    bnc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // stack and verdict
    bnc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .balanced     (balanced),
        .status       (status)
    );

endmodule

[rtl/core/bnc_checker.sv]
// port level assertions for the bracket nesting checker, bound to the top
module bnc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic        is_last,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic        balanced,
    input  logic [1:0]  status
);

    localparam int PEND_W = $clog2(bnc_pkg::QUEUE_DEPTH + 3);

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              last_beat;
    logic              res_beat;

    assign last_beat = char_valid && char_ready && is_last;
    assign res_beat  = result_valid && result_ready;

    // final beats taken but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if (last_beat && !res_beat)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (res_beat && !last_beat)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(balanced) && $stable(status))
        else $error("result beat changed while stalled");

    // verdict agrees with status
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (balanced == (status == bnc_pkg::ST_OK)))
        else $error("balanced disagrees with status");

    // no result without a final byte before it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pend_reg != '0))
        else $error("result without a pending final byte");

    // outstanding expressions stay within queue plus result slot
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(bnc_pkg::QUEUE_DEPTH + 1))
        else $error("too many unanswered expressions");

endmodule

bind bracket_nesting_checker_unit bnc_checker u_bnc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .balanced     (balanced),
    .status       (status)
);

[tb/sv/bracket_verdict_checker.sv]
// watches both channels of the bracket checker, predicts each verdict and compares it
`timescale 1ns / 1ps

module bracket_verdict_checker
    import bnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_ready,
    input  logic [7:0] char_in,
    input  logic       is_last,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic       balanced,
    input  logic [1:0] status,
    output int         fail_count,
    output int         pending
);

    typedef struct {
        logic    balanced;
        status_t status;
    } verdict_t;

    // predicted verdicts not yet seen on the output
    verdict_t   verdict_q[$];

    // shadow of the bracket stack and of the sticky failure
    logic [1:0] kind_stack [STACK_DEPTH];
    int         depth;
    status_t    first_fail;
    int         errors = 0;
    int         waiting = 0;

    assign fail_count = errors;
    assign pending    = waiting;

    // kind pushed by an opening bracket
    function automatic logic [1:0] opener_kind(input logic [7:0] c);
        case (c)
            CH_LROUND:  return KIND_ROUND;
            CH_LCURLY:  return KIND_CURLY;
            CH_LSQUARE: return KIND_SQUARE;
            default:    return KIND_NONE;
        endcase
    endfunction

    // kind expected by a closing bracket
    function automatic logic [1:0] closer_kind(input logic [7:0] c);
        case (c)
            CH_RROUND:  return KIND_ROUND;
            CH_RCURLY:  return KIND_CURLY;
            CH_RSQUARE: return KIND_SQUARE;
            default:    return KIND_NONE;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // one text byte through the shadow stack, verdict queued on the final byte
    task automatic nest_step(input logic [7:0] c, input logic last);
        logic [1:0] ok;
        logic [1:0] ck;
        verdict_t   v;
        ok = opener_kind(c);
        ck = closer_kind(c);
        if (first_fail == ST_OK) begin
            if (ok != KIND_NONE) begin
                if (depth >= STACK_DEPTH) begin
                    first_fail = ST_OVERFLOW;
                end
                else begin
                    kind_stack[depth] = ok;
                    depth++;
                end
            end
            else if (ck != KIND_NONE) begin
                if (depth == 0) begin
                    first_fail = ST_MISMATCH;
                end
                else begin
                    depth--;
                    if (kind_stack[depth] != ck)
                        first_fail = ST_MISMATCH;
                end
            end
        end
        if (last) begin
            if (first_fail != ST_OK)
                v.status = first_fail;
            else if (depth != 0)
                v.status = ST_OPEN;
            else
                v.status = ST_OK;
            v.balanced = (v.status == ST_OK);
            verdict_q.push_back(v);
            depth      = 0;
            first_fail = ST_OK;
        end
    endtask

    // compare a result beat against the oldest prediction
    task automatic check_result();
        verdict_t v;
        if (verdict_q.size() == 0) begin
            report_error($sformatf("result beat with none expected (balanced %0b status %0d)",
                                   balanced, status));
        end
        else begin
            v = verdict_q.pop_front();
            if (balanced !== v.balanced)
                report_error($sformatf("balanced expected %0b got %0b", v.balanced, balanced));
            if (status !== v.status)
                report_error($sformatf("status expected %0d got %0d", v.status, status));
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            verdict_q.delete();
            depth      = 0;
            first_fail = ST_OK;
        end
        else begin
            if (result_valid && result_ready)
                check_result();
            if (char_valid && char_ready)
                nest_step(char_in, is_last);
        end
        waiting = verdict_q.size();
    end

endmodule

[tb/sv/tb_top.sv]
// top of the bracket checker testbench: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 1ps

module tb_top;
    import bnc_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_MISMATCH,
        SHAPE_STRAY,
        SHAPE_OPEN,
        SHAPE_NOISE
    } shape_t;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_ready;
    logic [7:0] char_in;
    logic       is_last;
    logic       result_valid;
    logic       result_ready;
    logic       balanced;
    logic [1:0] status;

    int         fail_n;
    int         expected_n;

    logic [7:0] expr_q[$];
    int         sent_n      = 0;
    int         burst_left  = 1;
    bit         offering    = 1'b0;
    logic       hold_req    = 1'b0;
    bit         hold_done   = 1'b0;
    int         idle_cycles = 0;

    bracket_nesting_checker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_in      (char_in),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .balanced     (balanced),
        .status       (status)
    );

    bracket_verdict_checker verdict_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_in      (char_in),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .balanced     (balanced),
        .status       (status),
        .fail_count   (fail_n),
        .pending      (expected_n)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // known values on every input from time zero
    initial
    begin
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_in      = 8'h00;
        is_last      = 1'b0;
        result_ready = 1'b0;
    end

    function automatic logic [7:0] opener_char(input logic [1:0] k);
        case (k)
            KIND_ROUND: return CH_LROUND;
            KIND_CURLY: return CH_LCURLY;
            default:    return CH_LSQUARE;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input logic [1:0] k);
        case (k)
            KIND_ROUND: return CH_RROUND;
            KIND_CURLY: return CH_RCURLY;
            default:    return CH_RSQUARE;
        endcase
    endfunction

    function automatic logic [1:0] rand_kind();
        return 2'($urandom_range(KIND_ROUND, KIND_SQUARE));
    endfunction

    // any text byte that is not a bracket
    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LROUND || c == CH_RROUND || c == CH_LCURLY ||
               c == CH_RCURLY || c == CH_LSQUARE || c == CH_RSQUARE);
        return c;
    endfunction

    // offer one beat, hold it until taken, then maybe end the burst
    task automatic send_beat(input logic [7:0] c, input logic last);
        int gap;
        char_valid <= 1'b1;
        char_in    <= c;
        is_last    <= last;
        offering    = 1'b1;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        sent_n++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
            char_valid <= 1'b0;
            offering    = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // send the built expression, final byte flagged
    task automatic send_expr();
        for (int i = 0; i < expr_q.size(); i++)
            send_beat(expr_q[i], i == expr_q.size() - 1);
    endtask

    // stop offering and wait for every outstanding verdict
    task automatic wait_all_results();
        if (offering) begin
            char_valid <= 1'b0;
            offering    = 1'b0;
            @(posedge clk);
        end
        while (expected_n != 0)
            @(posedge clk);
    endtask

    // random expression of the given shape, short and shallow
    task automatic build_expr(input shape_t shape);
        logic [1:0] open_kinds[$];
        logic [1:0] k;
        logic [1:0] w;
        int         len;
        int         max_depth;
        int         pick;
        expr_q.delete();
        len       = $urandom_range(1, 24);
        max_depth = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 2);
            if (shape == SHAPE_NOISE) begin
                if (pick == 0)
                    expr_q.push_back($urandom_range(0, 1) ? opener_char(rand_kind())
                                                          : closer_char(rand_kind()));
                else
                    expr_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick == 0 && open_kinds.size() < max_depth) begin
                k = rand_kind();
                expr_q.push_back(opener_char(k));
                open_kinds.push_back(k);
            end
            else if (pick == 1 && open_kinds.size() > 0) begin
                expr_q.push_back(closer_char(open_kinds.pop_back()));
            end
            else begin
                expr_q.push_back(filler_byte());
            end
        end
        // shape the tail
        if (shape == SHAPE_MISMATCH) begin
            if (open_kinds.size() == 0) begin
                k = rand_kind();
                expr_q.push_back(opener_char(k));
                open_kinds.push_back(k);
            end
            k = open_kinds.pop_back();
            do
                w = rand_kind();
            while (w == k);
            expr_q.push_back(closer_char(w));
        end
        if (shape == SHAPE_OPEN && open_kinds.size() == 0)
            expr_q.push_back(opener_char(rand_kind()));
        if (shape != SHAPE_OPEN && shape != SHAPE_NOISE) begin
            while (open_kinds.size() > 0)
                expr_q.push_back(closer_char(open_kinds.pop_back()));
        end
        if (shape == SHAPE_STRAY)
            expr_q.push_back(closer_char(rand_kind()));
        if ($urandom_range(0, 3) == 0)
            expr_q.push_back(filler_byte());
    endtask

    // deep nest: n_open openers then n_close closers, matching while openers remain
    task automatic build_deep(input int n_open, input int n_close);
        logic [1:0] open_kinds[$];
        logic [1:0] k;
        expr_q.delete();
        for (int i = 0; i < n_open; i++) begin
            k = rand_kind();
            expr_q.push_back(opener_char(k));
            open_kinds.push_back(k);
        end
        for (int i = 0; i < n_close; i++) begin
            if (open_kinds.size() > 0)
                expr_q.push_back(closer_char(open_kinds.pop_back()));
            else
                expr_q.push_back(closer_char(rand_kind()));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int     random_start;
        int     expr_n;
        int     r;
        shape_t shape;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, each bracket pair, each failure kind but overflow
        expr_q = '{8'h00};                                 send_expr();
        expr_q = '{8'hFF};                                 send_expr();
        expr_q = '{CH_LROUND, CH_RROUND};                  send_expr();
        expr_q = '{CH_LCURLY, CH_RCURLY};                  send_expr();
        expr_q = '{CH_LSQUARE, CH_RSQUARE};                send_expr();
        // stray close on empty stack
        expr_q = '{CH_RCURLY};                             send_expr();
        // kind mismatch
        expr_q = '{CH_LROUND, CH_RSQUARE};                 send_expr();
        // left open
        expr_q = '{CH_LSQUARE, CH_LCURLY};                 send_expr();
        // sticky failure: stray close, then a clean pair
        expr_q = '{CH_RSQUARE, CH_LROUND, CH_RROUND};      send_expr();
        // nested pairs then a stray close
        expr_q = '{CH_LCURLY, CH_LSQUARE, CH_RSQUARE, CH_RCURLY, CH_RROUND};
        send_expr();
        expr_q = '{8'h41, CH_LROUND, 8'h20, CH_RROUND};    send_expr();

        // random expressions
        random_start = sent_n;
        expr_n       = 0;
        while (sent_n - random_start < RANDOM_ITEMS) begin
            expr_n++;
            if (expr_n == 8) begin
                // fill the stack exactly, then unwind it
                build_deep(STACK_DEPTH, STACK_DEPTH);
            end
            else if (expr_n == 20 || expr_n == 60) begin
                // overflow, with closes after it
                build_deep(STACK_DEPTH + $urandom_range(1, 3), $urandom_range(1, 6));
            end
            else begin
                if (expr_n == 35)
                    hold_req <= 1'b1;
                if (expr_n == 50)
                    wait_all_results();
                r = $urandom_range(0, 9);
                if (r <= 5)
                    shape = SHAPE_GOOD;
                else if (r == 6)
                    shape = SHAPE_MISMATCH;
                else if (r == 7)
                    shape = SHAPE_STRAY;
                else if (r == 8)
                    shape = SHAPE_OPEN;
                else
                    shape = SHAPE_NOISE;
                build_expr(shape);
            end
            send_expr();
        end

        // drain and give the verdict
        wait_all_results();
        repeat (20) @(posedge clk);
        if (fail_n == 0 && expected_n == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // output side: stall pattern of its own, plus one long hold-off
    initial
    begin
        rx_mode_t mode;
        int       span;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 120);
            for (int i = 0; i < span; i++) begin
                if (hold_req && !hold_done) begin
                    result_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    RX_ALWAYS: result_ready <= 1'b1;
                    RX_HALF:   result_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                    default:   result_ready <= ((i % 5) < 3);
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((char_valid && char_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
